FILE: design/pmc_pkg.sv
// Shared types and constants for the polynomial multiply convolution core.
// No dependencies; imported by pmc_mac, pmc_seq and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pmc_pkg;

  localparam int unsigned COEF_W   = 16;
  localparam int unsigned PROD_W   = 36;
  localparam int unsigned MUL_W    = 2 * COEF_W;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // Register indexes (word address on the config port)
  localparam logic [PADDR_W-3:0] REG_LEN_LOG2 = 1'b0;

  localparam logic [LEN_W-1:0] LEN_LOG2_RESET = 3'd2;

  // Tag that travels with one multiply-accumulate term
  typedef struct packed {
    logic valid;
    logic first;
  } pmc_issue_t;

endpackage : pmc_pkg

`default_nettype wire

FILE: design/pmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pmc_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : pmc_ram

`default_nettype wire

FILE: design/pmc_mac.sv
// Shared multiply-accumulate unit: product register, then 36-bit accumulator.
// Depends on pmc_pkg for widths and the issue tag type.
`timescale 1ns / 1ps
`default_nettype none

module pmc_mac
  import pmc_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire pmc_issue_t               issue_i,
  input  wire logic signed [COEF_W-1:0] a_rd_i,
  input  wire logic signed [COEF_W-1:0] b_rd_i,
  output logic                          busy_o,
  output logic signed [PROD_W-1:0]      acc_o
);

  pmc_issue_t              tag1_q, tag2_q;
  logic signed [MUL_W-1:0]  prod_q;
  logic signed [PROD_W-1:0] acc_q, acc_d;

  // tag1 lines up with the RAM read data, tag2 with the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= issue_i;
      tag2_q <= tag1_q;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (tag2_q.valid) begin
      if (tag2_q.first) begin
        acc_d = PROD_W'(prod_q);
      end else begin
        acc_d = acc_q + PROD_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_rd_i * b_rd_i;
    acc_q  <= acc_d;
  end

  assign busy_o = tag1_q.valid | tag2_q.valid;
  assign acc_o  = acc_q;

endmodule : pmc_mac

`default_nettype wire

FILE: design/pmc_seq.sv
// Sequencer: loads coefficient pairs, walks the (k, i) term loop over the
// shared MAC and holds the output register. Depends on pmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmc_seq
  import pmc_pkg::*;
#(
  parameter int unsigned AW = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [AW-1:0]        n_m1_i,
  input  wire logic                 cfg_clear_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      ram_we_o,
  output logic [AW-1:0]             ram_waddr_o,
  output logic [AW-1:0]             a_raddr_o,
  output logic [AW-1:0]             b_raddr_o,
  output pmc_issue_t                issue_o,
  input  wire logic                 mac_busy_i,
  input  wire logic signed [PROD_W-1:0] acc_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [PROD_W-1:0]  prod_coef_o,
  output logic [INDEX_W-1:0]        prod_index_o,
  output logic                      last_coef_o
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_ISSUE,
    S_EMIT
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            cnt_q, cnt_d;
  logic [AW:0]              k_q, k_d;
  logic [AW-1:0]            i_q, i_d;
  logic [AW-1:0]            j_q, j_d;
  logic                     first_q, first_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [PROD_W-1:0] coef_q, coef_d;
  logic [INDEX_W-1:0]       index_q, index_d;
  logic                     last_q, last_d;

  logic          accept;
  logic          term_last;
  logic [AW:0]   k_max;
  logic [AW:0]   k_nx;
  logic [AW:0]   n_m1_ext;
  logic [AW:0]   i_start;
  logic          slot_free;

  assign accept    = in_valid_i && (state_q == S_LOAD);
  assign term_last = (j_q == '0) || (i_q == n_m1_i);
  assign k_max     = {n_m1_i, 1'b0};
  assign k_nx      = k_q + 1'b1;
  assign n_m1_ext  = {1'b0, n_m1_i};
  assign i_start   = k_nx - n_m1_ext;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    coef_d      = coef_q;
    index_d     = index_q;
    last_d      = last_q;

    // drop the held result once it is taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (cnt_q == n_m1_i) begin
            cnt_d   = '0;
            k_d     = '0;
            i_d     = '0;
            j_d     = '0;
            first_d = 1'b1;
            state_d = S_ISSUE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_ISSUE: begin
        first_d = 1'b0;
        if (term_last) begin
          state_d = S_EMIT;
        end else begin
          i_d = i_q + 1'b1;
          j_d = j_q - 1'b1;
        end
      end
      S_EMIT: begin
        if (!mac_busy_i && slot_free) begin
          out_valid_d = 1'b1;
          coef_d      = acc_i;
          index_d     = INDEX_W'(k_q);
          last_d      = (k_q == k_max);
          if (k_q == k_max) begin
            state_d = S_LOAD;
          end else begin
            k_d     = k_nx;
            first_d = 1'b1;
            state_d = S_ISSUE;
            if (k_nx <= n_m1_ext) begin
              i_d = '0;
              j_d = k_nx[AW-1:0];
            end else begin
              i_d = i_start[AW-1:0];
              j_d = n_m1_i;
            end
          end
        end
      end
      default: state_d = S_LOAD;
    endcase

    if (cfg_clear_i) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      coef_q      <= '0;
      index_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      coef_q      <= coef_d;
      index_q     <= index_d;
      last_q      <= last_d;
    end
  end

  assign in_stall_o    = (state_q != S_LOAD);
  assign ram_we_o      = accept;
  assign ram_waddr_o   = cnt_q;
  assign a_raddr_o     = i_q;
  assign b_raddr_o     = j_q;
  assign issue_o.valid = (state_q == S_ISSUE);
  assign issue_o.first = first_q;
  assign out_valid_o   = out_valid_q;
  assign prod_coef_o   = coef_q;
  assign prod_index_o  = index_q;
  assign last_coef_o   = last_q;

endmodule : pmc_seq

`default_nettype wire

FILE: design/polynomial_multiply_convolution_core.sv
// Top level of the polynomial multiply convolution core: config register,
// coefficient RAMs, sequencer and shared MAC. Depends on pmc_pkg, pmc_ram,
// pmc_mac and pmc_seq.
//
//   channel  | handshake                          | payload
//   ---------+------------------------------------+--------------------------------
//   input    | in_valid_i / in_stall_o            | a_coef_i, b_coef_i
//   output   | out_valid_o / out_stall_i          | prod_coef_o, prod_index_o, last_coef_o
//   config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// Flow: a request that does not complete a run only writes the coefficient
// RAMs. The final request of a run starts the convolution on the single
// shared multiplier: each product coefficient passes through RAM read,
// product register and accumulate, and in_stall_o stays high until the
// last coefficient has been handed to the output register.
// Reset: control state clears, len_log2 returns to 2; coefficient RAMs are
// not cleared, since every run writes all entries it reads.
// Stalls: the output register holds a result while out_stall_i is high;
// the sequencer waits to hand over the next coefficient until it is free.
`timescale 1ns / 1ps
`default_nettype none

module polynomial_multiply_convolution_core
  import pmc_pkg::*;
#(
  parameter int unsigned MAX_LEN = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input request channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [COEF_W-1:0]  a_coef_i,
  input  wire logic signed [COEF_W-1:0]  b_coef_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [PROD_W-1:0]       prod_coef_o,
  output logic [INDEX_W-1:0]             prod_index_o,
  output logic                           last_coef_o,
  // config port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [PADDR_W-1:0]        paddr,
  input  wire logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]             prdata,
  output logic                           pready
);

  localparam int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  // largest power of two that fits in MAX_LEN, as a log2
  localparam int unsigned MaxLog2 = $clog2(MAX_LEN + 1) - 1;

  logic [LEN_W-1:0]         len_q;
  logic [LEN_W-1:0]         len_eff;
  logic [AW:0]              n_full;
  logic [AW:0]              n_minus;
  logic [AW-1:0]            n_m1;
  logic                     cfg_wr;
  logic [PADDR_W-3:0]       reg_idx;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [AW-1:0]            a_raddr;
  logic [AW-1:0]            b_raddr;
  logic [COEF_W-1:0]        a_rd;
  logic [COEF_W-1:0]        b_rd;
  pmc_issue_t               issue;
  logic                     mac_busy;
  logic signed [PROD_W-1:0] acc;

  // Config register: write on the access phase, ignore other indexes
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_LEN_LOG2);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_LOG2_RESET;
    end else if (cfg_wr) begin
      len_q <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEN_LOG2: prdata = PDATA_W'(len_q);
      default:      prdata = '0;
    endcase
  end

  // Clamp the run length to what the RAMs hold
  assign len_eff = (len_q > LEN_W'(MaxLog2)) ? LEN_W'(MaxLog2) : len_q;
  assign n_full  = (AW + 1)'(1) << len_eff;
  assign n_minus = n_full - (AW + 1)'(1);
  assign n_m1    = n_minus[AW-1:0];

  pmc_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_LEN),
    .ADDR_W(AW)
  ) u_a_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(a_coef_i),
    .raddr_i(a_raddr),
    .rdata_o(a_rd)
  );

  pmc_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_LEN),
    .ADDR_W(AW)
  ) u_b_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(b_coef_i),
    .raddr_i(b_raddr),
    .rdata_o(b_rd)
  );

  pmc_seq #(
    .AW(AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_m1_i      (n_m1),
    .cfg_clear_i (cfg_wr),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .a_raddr_o   (a_raddr),
    .b_raddr_o   (b_raddr),
    .issue_o     (issue),
    .mac_busy_i  (mac_busy),
    .acc_i       (acc),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prod_coef_o (prod_coef_o),
    .prod_index_o(prod_index_o),
    .last_coef_o (last_coef_o)
  );

  pmc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .issue_i(issue),
    .a_rd_i ($signed(a_rd)),
    .b_rd_i ($signed(b_rd)),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

endmodule : polynomial_multiply_convolution_core

`default_nettype wire
